FILE: rtl/square_and_multiply_power_defines.svh
// Assertion macros used by the checker file
`ifndef SQUARE_AND_MULTIPLY_POWER_DEFINES_SVH
`define SQUARE_AND_MULTIPLY_POWER_DEFINES_SVH

// Implication checked every clock, quiet in reset
`define SAMP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet in reset
`define SAMP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/samp_pkg.sv
package samp_pkg;
   localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;

   // Widen a single-precision pattern to double exactly
   function automatic logic [63:0] widen_base(input logic [31:0] b);
      logic        s;
      logic [7:0]  e;
      logic [22:0] m;
      logic [22:0] mm;
      logic [10:0] de;
      logic [4:0]  lz;
      logic        found;
      logic [63:0] r;
      s = b[31];
      e = b[30:23];
      m = b[22:0];
      lz = 5'd0;
      found = 1'b0;
      mm = m;
      de = 11'd0;
      if (e == 8'hFF) begin
         if (m != 23'd0) r = CANON_NAN;
         else r = {s, 11'h7FF, 52'd0};
      end else if (e == 8'd0) begin
         if (m == 23'd0) r = {s, 63'd0};
         else begin
            for (int i = 22; i >= 0; i--) begin
               if (!found && m[i]) begin
                  found = 1'b1;
                  lz = 5'(22 - i);
               end
            end
            mm = m << (lz + 5'd1);
            de = 11'(1023 - 127 - lz);
            r = {s, de, mm, 29'd0};
         end
      end else begin
         de = 11'(e) + 11'd896;
         r = {s, de, m, 29'd0};
      end
      return r;
   endfunction
endpackage

FILE: rtl/samp_fmul.sv
// Iterative double multiplier, round to nearest even.
// Latch the operands on start, build the 106-bit significand product from four
// 27x27 partial products, one a cycle, then round; done is registered from the round phase.
module samp_fmul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] prod
);
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_P0   = 3'd1;
   localparam logic [2:0] PH_P1   = 3'd2;
   localparam logic [2:0] PH_P2   = 3'd3;
   localparam logic [2:0] PH_P3   = 3'd4;
   localparam logic [2:0] PH_RND  = 3'd5;

   logic [2:0]   phase_ff, phase_in;
   logic         done_ff, done_in;
   logic         sgn_ff, sgn_in;
   logic         spec_ff, spec_in;
   logic [63:0]  spec_val_ff, spec_val_in;
   logic signed [13:0] ex_ff, ex_in;
   logic [52:0]  ma_ff, ma_in;
   logic [52:0]  mb_ff, mb_in;
   logic [105:0] mp_ff, mp_in;
   logic [63:0]  prod_ff, prod_in;

   logic [10:0] ea, eb;
   logic [51:0] fa, fb;
   logic        za, zb, ia, ib, na, nb;
   logic [5:0]  la, lb;
   logic        fda, fdb;

   logic [26:0]  pa, pb;
   logic [53:0]  pp;
   logic [105:0] ppw;

   always_comb begin
      ea = a[62:52]; eb = b[62:52];
      fa = a[51:0];  fb = b[51:0];
      za = (ea == 11'd0) && (fa == 52'd0);
      zb = (eb == 11'd0) && (fb == 52'd0);
      ia = (ea == 11'h7FF) && (fa == 52'd0);
      ib = (eb == 11'h7FF) && (fb == 52'd0);
      na = (ea == 11'h7FF) && (fa != 52'd0);
      nb = (eb == 11'h7FF) && (fb != 52'd0);
      sgn_in = a[63] ^ b[63];
      // normalize subnormal operands
      la = 6'd0; lb = 6'd0; fda = 1'b0; fdb = 1'b0;
      for (int i = 52; i >= 0; i--) begin
         if (!fda && ((ea != 11'd0) ? (i == 52) : ((i < 52) && fa[i]))) begin
            fda = 1'b1; la = 6'(52 - i);
         end
         if (!fdb && ((eb != 11'd0) ? (i == 52) : ((i < 52) && fb[i]))) begin
            fdb = 1'b1; lb = 6'(52 - i);
         end
      end
      ma_in = {(ea != 11'd0), fa} << la;
      mb_in = {(eb != 11'd0), fb} << lb;
      ex_in = 14'($signed({3'd0, ((ea == 11'd0) ? 11'd1 : ea)}))
            + 14'($signed({3'd0, ((eb == 11'd0) ? 11'd1 : eb)}))
            - 14'($signed({8'd0, la})) - 14'($signed({8'd0, lb})) - 14'sd1023;
      spec_in = 1'b1;
      spec_val_in = 64'd0;
      if (na || nb || (ia && zb) || (za && ib)) spec_val_in = samp_pkg::CANON_NAN;
      else if (ia || ib) spec_val_in = {sgn_in, 11'h7FF, 52'd0};
      else if (za || zb) spec_val_in = {sgn_in, 63'd0};
      else spec_in = 1'b0;
   end

   // sequencer: one partial product a cycle into the accumulator
   always_comb begin
      phase_in = phase_ff;
      mp_in = mp_ff;
      case (phase_ff)
         PH_P0: begin
            pa = ma_ff[26:0]; pb = mb_ff[26:0];
         end
         PH_P1: begin
            pa = ma_ff[26:0]; pb = {1'b0, mb_ff[52:27]};
         end
         PH_P2: begin
            pa = {1'b0, ma_ff[52:27]}; pb = mb_ff[26:0];
         end
         PH_P3: begin
            pa = {1'b0, ma_ff[52:27]}; pb = {1'b0, mb_ff[52:27]};
         end
         default: begin
            pa = 27'd0; pb = 27'd0;
         end
      endcase
      pp = {27'd0, pa} * {27'd0, pb};
      ppw = {52'd0, pp};
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               mp_in = '0; phase_in = PH_P0;
            end
         end
         PH_P0: begin
            mp_in = mp_ff + ppw; phase_in = PH_P1;
         end
         PH_P1: begin
            mp_in = mp_ff + (ppw << 27); phase_in = PH_P2;
         end
         PH_P2: begin
            mp_in = mp_ff + (ppw << 27); phase_in = PH_P3;
         end
         PH_P3: begin
            mp_in = mp_ff + (ppw << 54); phase_in = PH_RND;
         end
         PH_RND: phase_in = PH_IDLE;
         default: phase_in = PH_IDLE;
      endcase
      done_in = (phase_ff == PH_RND);
   end

   // normalize, round, pack
   logic [105:0] mn;
   logic signed [13:0] en;
   logic [7:0]   sh;
   logic [107:0] wide;
   logic [52:0]  keep;
   logic         g, st;
   logic [53:0]  rnd;
   logic signed [13:0] ef;
   always_comb begin
      mn = mp_ff[105] ? mp_ff : (mp_ff << 1);
      en = mp_ff[105] ? ex_ff + 14'sd1 : ex_ff;
      // mn[105] is the leading one, true exponent en
      sh = 8'd0;
      if (en < 14'sd1) sh = ((14'sd1 - en) > 14'sd60) ? 8'd60 : 8'(14'sd1 - en);
      wide = {mn, 2'b00} >> sh;
      keep = wide[107:55];
      g = wide[54];
      st = (wide[53:0] != 54'd0);
      rnd = {1'b0, keep} + 54'(g && (st || keep[0]));
      ef = (en < 14'sd1) ? 14'sd0 : en;
      if (rnd[53]) begin
         rnd = rnd >> 1;
         ef = ef + 14'sd1;
      end else if ((ef == 14'sd0) && rnd[52]) begin
         ef = 14'sd1;
      end
      if (spec_ff) prod_in = spec_val_ff;
      else if (ef >= 14'sd2047) prod_in = {sgn_ff, 11'h7FF, 52'd0};
      else prod_in = {sgn_ff, ef[10:0], rnd[51:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      if (start && (phase_ff == PH_IDLE)) begin
         sgn_ff <= sgn_in;
         spec_ff <= spec_in;
         spec_val_ff <= spec_val_in;
         ex_ff <= ex_in;
         ma_ff <= ma_in;
         mb_ff <= mb_in;
      end
      mp_ff <= mp_in;
      if (phase_ff == PH_RND) prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;
endmodule

FILE: rtl/square_and_multiply_power.sv
// Sequence: from the accepting edge, scan the exponent down to its top set bit (all bits
// for a zero exponent), then square once per lower bit and multiply once per set lower bit.
// Throughput: one item at a time; req_tready is low from accept until the rsp beat,
// so a new accept waits for the previous rsp beat. Each multiplication runs
// in one shared iterative double multiplier; a result waits in the output register.
// reset (synchronous, active high) clears the sequencer and valid flags.
module square_and_multiply_power #(
   parameter int EXP_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [31:0] base_bits, [47:32] exponent
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // [63:0] power_bits, [68:64] mult_count, rest zero
);
   localparam int IW = (EXP_BITS > 16) ? 16 : EXP_BITS;
   localparam int BW = $clog2(EXP_BITS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_SQ   = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [63:0]         x_ff, x_in;
   logic [63:0]         acc_ff, acc_in;
   logic [EXP_BITS-1:0] n_ff, n_in;
   logic [BW-1:0]       bit_ff, bit_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic                wait_ff, wait_in;

   logic        mstart, mdone;
   logic [63:0] ma, mprod;

   samp_fmul u_fmul (
      .clock (clock), .reset (reset), .start (mstart),
      .a (ma), .b (acc_ff), .done (mdone), .prod (mprod)
   );

   always_comb begin
      state_in = state_ff; x_in = x_ff; acc_in = acc_ff; n_in = n_ff;
      bit_in = bit_ff; cnt_in = cnt_ff; wait_in = wait_ff;
      mstart = 1'b0;
      ma = (state_ff == ST_MUL) ? x_ff : acc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               x_in = samp_pkg::widen_base(req_tdata[31:0]);
               n_in = EXP_BITS'(req_tdata[32 +: IW]);
               acc_in = samp_pkg::ONE_BITS;
               cnt_in = 5'd0;
               bit_in = BW'(EXP_BITS - 1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // walk down to the top set bit, one bit a cycle
            if (n_ff[bit_ff]) begin
               acc_in = x_ff;
               if (bit_ff == '0) state_in = ST_OUT;
               else begin
                  bit_in = bit_ff - 1'b1; state_in = ST_SQ; wait_in = 1'b0;
               end
            end else if (bit_ff == '0) state_in = ST_OUT;
            else bit_in = bit_ff - 1'b1;
         end
         ST_SQ, ST_MUL: begin
            if (!wait_ff) begin
               mstart = 1'b1; wait_in = 1'b1;
            end else if (mdone) begin
               acc_in = mprod; cnt_in = cnt_ff + 5'd1; wait_in = 1'b0;
               if (state_ff == ST_SQ && n_ff[bit_ff]) state_in = ST_MUL;
               else if (bit_ff == '0) state_in = ST_OUT;
               else begin
                  bit_in = bit_ff - 1'b1; state_in = ST_SQ;
               end
            end
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
      end
      x_ff <= x_in; acc_ff <= acc_in; n_ff <= n_in;
      bit_ff <= bit_in; cnt_ff <= cnt_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {3'd0, cnt_ff, acc_ff};
endmodule

FILE: rtl/samp_checker.sv
`include "square_and_multiply_power_defines.svh"
module samp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);
   `SAMP_ASSERT_IMP(a_excl, clock, reset, rsp_tvalid, !req_tready, "ready while result held")
   `SAMP_ASSERT_NXT(a_busy, clock, reset, req_tvalid && req_tready, !req_tready, "ready after accept")
   `SAMP_ASSERT_NXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped")
   `SAMP_ASSERT_IMP(a_pad, clock, reset, rsp_tvalid, rsp_tdata[71:69] == 3'd0, "pad bits set")
endmodule

bind square_and_multiply_power samp_checker u_samp_checker (
   .clock (clock), .reset (reset), .req_tvalid (req_tvalid), .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid), .rsp_tready (rsp_tready), .rsp_tdata (rsp_tdata)
);

FILE: test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EXP_BITS    = 16;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_WAIT  = EXP_BITS + 7 * 2 * (EXP_BITS - 1) + 20;

   // One expected result beat
   typedef struct packed {
      logic [63:0] power_bits;
      logic [4:0]  mult_count;
   } power_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;     // [31:0] base_bits, [47:32] exponent
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;     // [63:0] power_bits, [68:64] mult_count, rest zero

   power_result_type pending_powers[$];
   int            error_count;
   int            cycle_count;
   bit            quiet_mode;      // no idling on either side while set
   int            holdoff_cycles;  // receiver stall requested by a test

   square_and_multiply_power #(.EXP_BITS(EXP_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Widen a single-precision pattern into a real value, exactly
   function automatic real single_to_real(input logic [31:0] b);
      real scale;
      real mag;
      int  shift;
      shift = (b[30:23] == 8'd0) ? -149 : int'(b[30:23]) - 150;
      mag = (b[30:23] == 8'd0) ? real'(b[22:0]) : real'({1'b1, b[22:0]});
      scale = 1.0;
      for (int i = 0; i < shift; i++) scale = scale * 2.0;
      for (int i = 0; i > shift; i--) scale = scale * 0.5;
      mag = mag * scale;
      return b[31] ? -mag : mag;
   endfunction

   function automatic bit is_nan64(input logic [63:0] d);
      return (d[62:52] == 11'h7FF) && (d[51:0] != 52'd0);
   endfunction

   // Predict x^n by walking n from its top set bit down
   function automatic power_result_type predict_power(input logic [31:0] base_bits,
                                                      input logic [15:0] exponent);
      power_result_type r;
      logic [15:0]   n;
      real           x;
      real           acc;
      logic [63:0]   acc_bits;
      int            top;
      int            muls;
      n = exponent;
      top = -1;
      muls = 0;
      for (int i = 0; i < EXP_BITS; i++) if (n[i]) top = i;
      if (base_bits[30:23] == 8'hFF) begin
         // infinities and NaN built by pattern, not by arithmetic
         x = $bitstoreal(base_bits[22:0] != 23'd0 ? samp_pkg::CANON_NAN :
                         {base_bits[31], 11'h7FF, 52'd0});
      end else begin
         x = single_to_real(base_bits);
      end
      if (top < 0) begin
         acc = 1.0;
      end else begin
         acc = x;
         for (int i = top - 1; i >= 0; i--) begin
            acc = acc * acc;
            muls++;
            if (n[i]) begin
               acc = x * acc;
               muls++;
            end
         end
      end
      acc_bits = $realtobits(acc);
      r.power_bits = is_nan64(acc_bits) ? samp_pkg::CANON_NAN : acc_bits;
      r.mult_count = 5'(muls);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h, want %h (cycle %0d)", what, got, want, cycle_count);
      error_count++;
   endtask

   // Offer one beat, hold it until accepted, then maybe idle
   task automatic send_power(input logic [31:0] base_bits, input logic [15:0] exponent);
      req_tvalid <= 1'b1;
      req_tdata  <= {exponent, base_bits};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_powers.push_back(predict_power(base_bits, exponent));
      if (!quiet_mode && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Base biased toward values whose powers stay finite for a while
   function automatic logic [31:0] pick_base();
      int sel;
      sel = $urandom_range(99);
      if (sel < 55)
         return {1'($urandom), 8'($urandom_range(125, 128)), 23'($urandom)};
      else if (sel < 65)
         return {1'($urandom), 8'd0, 23'($urandom)};
      else if (sel < 72)
         return {1'($urandom), 8'hFF, ($urandom_range(1) ? 23'($urandom) : 23'd0)};
      else
         return $urandom;
   endfunction

   function automatic logic [15:0] pick_exponent();
      int sel;
      sel = $urandom_range(99);
      if (sel < 60) return 16'($urandom_range(0, 40));
      else if (sel < 80) return 16'($urandom_range(0, 1023));
      else return 16'($urandom);
   endfunction

   // Receiver: random stalls, or a long hold-off on request
   always @(posedge clock) begin
      if (holdoff_cycles > 0) begin
         holdoff_cycles <= holdoff_cycles - 1;
         rsp_tready <= 1'b0;
      end else if (quiet_mode) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 18);
      end
   end

   // Check every accepted result beat against the oldest prediction
   always @(posedge clock) begin
      power_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_powers.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata[63:0], 64'd0);
         end else begin
            want = pending_powers.pop_front();
            if (rsp_tdata[63:0] !== want.power_bits)
               report_mismatch("power_bits", rsp_tdata[63:0], want.power_bits);
            if (rsp_tdata[68:64] !== want.mult_count)
               report_mismatch("mult_count", 64'(rsp_tdata[68:64]), 64'(want.mult_count));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic test_directed();
      send_power(32'h3F80_0000, 16'd0);        // zero exponent
      send_power(32'h7FC0_1234, 16'd0);        // zero exponent with NaN base
      send_power(32'h4049_0FDB, 16'd1);        // exponent one
      send_power(32'h0000_0001, 16'd1);        // smallest subnormal widened
      send_power(32'hFFFF_FFFF, 16'd1);        // NaN base, negative sign
      send_power(32'h4000_0000, 16'd10);
      send_power(32'hBF80_0000, 16'd65535);    // -1 to the largest power
      send_power(32'h3F80_0001, 16'd65535);    // most multiplications
      send_power(32'h7F7F_FFFF, 16'd2);        // largest finite single squared
      send_power(32'h0000_0001, 16'd2);        // smallest subnormal squared
      send_power(32'h7F80_0000, 16'd3);        // infinity base
      send_power(32'hFF80_0000, 16'd2);
      send_power(32'h8000_0000, 16'd3);        // negative zero
      send_power(32'h8000_0000, 16'd4);
      send_power(32'h3F00_0000, 16'd1074);     // down to the smallest subnormal
      send_power(32'h3FB5_04F3, 16'd32768);
      send_power(32'h0080_0000, 16'd1);
      send_power(32'hC000_0000, 16'd1023);
      send_power(32'h3F7F_FFFF, 16'd12345);
      send_power(32'h0040_0000, 16'd5);
      req_tvalid <= 1'b0;
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) send_power(pick_base(), pick_exponent());
      req_tvalid <= 1'b0;
   endtask

   // Stall the receiver while the sender keeps offering beats
   task automatic test_backpressure();
      holdoff_cycles = 400;
      for (int i = 0; i < 12; i++) send_power(pick_base(), 16'($urandom_range(0, 20)));
      req_tvalid <= 1'b0;
   endtask

   task automatic test_no_idle(input int count);
      quiet_mode = 1'b1;
      test_random(count);
      quiet_mode = 1'b0;
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      error_count    = 0;
      cycle_count    = 0;
      quiet_mode     = 1'b0;
      holdoff_cycles = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(700);
      test_backpressure();
      test_no_idle(300);
      test_random(580);

      // drain, then give the block its full latency to misbehave
      while (pending_powers.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
